FILE: sv/prt_pkg.sv
// Package for the partition replica route table: sizes, codes and slot types.
`timescale 1ns / 1ps
`default_nettype none
package prt_pkg;

  localparam int unsigned PARTITIONS = 4096;
  localparam int unsigned NAMESPACES = 4;
  localparam int unsigned NODES      = 64;

  localparam int unsigned PART_W  = $clog2(PARTITIONS);
  localparam int unsigned NS_W    = $clog2(NAMESPACES);
  localparam int unsigned NODE_W  = $clog2(NODES);
  localparam int unsigned OP_W    = 3;
  localparam int unsigned ADDR_W  = NS_W + PART_W;
  localparam int unsigned DEPTH   = NAMESPACES * PARTITIONS;

  typedef enum logic [OP_W-1:0] {
    OP_UPDATE   = 3'd0,
    OP_LOOKUP   = 3'd1,
    OP_PRESENCE = 3'd2,
    OP_THROTTLE = 3'd3,
    OP_CLEAR    = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    ST_CLR,
    ST_IDLE,
    ST_UPD,
    ST_LKP,
    ST_SCAN_M,
    ST_SCAN_R,
    ST_RESP
  } state_e;

  // one table row: master slot and replica slot
  typedef struct packed {
    logic              m_ok;
    logic [NODE_W-1:0] m_node;
    logic              r_ok;
    logic [NODE_W-1:0] r_node;
  } entry_t;

  typedef struct packed {
    logic [NODE_W-1:0] chosen_node;
    logic              node_valid;
    logic              node_present;
  } res_t;

endpackage
`default_nettype wire

FILE: sv/partition_replica_route_table.sv
// Partition replica route table: slot memory, sequencer and result register.
//
//  Channel | Signals                                     | Direction
//  cfg     | cfg_we_i, cfg_wdata_i                       | in, no wait
//  in      | in_valid_i/in_ready_o, op_i .. throttled_i  | in
//  out     | out_valid_o/out_ready_i, chosen_node_o ..   | out
//
// Update and lookup: the slot row is read, then modified or answered.
// Set throttle and unused ops: zero result. Clear all: sweep of all 16384 rows of the
// slot memory (one row a cycle). Presence check: master pass of up to 16384
// reads, then if absent a replica pass over all rows clearing matching replica slots.
// After reset a clearing pass of all rows runs before the first beat is taken.
// A finished result sits in the output register; the next beat is taken
// while it waits, and a further result holds in a pending register.
`timescale 1ns / 1ps
`default_nettype none
module partition_replica_route_table (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cfg_we_i,
  input  wire                          cfg_wdata_i,
  input  wire                          in_valid_i,
  output logic                         in_ready_o,
  input  wire  [prt_pkg::OP_W-1:0]     op_i,
  input  wire  [prt_pkg::NODE_W-1:0]   node_id_i,
  input  wire  [prt_pkg::NS_W-1:0]     namespace_index_i,
  input  wire  [prt_pkg::PART_W-1:0]   partition_i,
  input  wire                          is_master_i,
  input  wire                          is_replica_i,
  input  wire                          is_write_i,
  input  wire                          throttled_i,
  output logic                         out_valid_o,
  input  wire                          out_ready_i,
  output logic [prt_pkg::NODE_W-1:0]   chosen_node_o,
  output logic                         node_valid_o,
  output logic                         node_present_o
);

  localparam int unsigned AW = prt_pkg::ADDR_W;
  localparam int unsigned NW = prt_pkg::NODE_W;

  prt_pkg::state_e state_q, state_d;
  logic [AW:0]     cnt_q, cnt_d;
  logic            rv_q, rv_d;
  logic [AW-1:0]   rtag_q, rtag_d;
  logic [prt_pkg::NAMESPACES-1:0] ns_use_q, ns_use_d;
  logic [prt_pkg::NODES-1:0]      thr_q, thr_d;
  logic            tog_q, tog_d;
  logic            rmo_q;
  logic            clr_res_q, clr_res_d;
  prt_pkg::res_t   res_q, res_d;
  logic            out_valid_q, out_valid_d;
  prt_pkg::res_t   out_q, out_d;

  // latched beat payload
  logic [NW-1:0]             node_q;
  logic [prt_pkg::NS_W-1:0]  ns_q;
  logic [prt_pkg::PART_W-1:0] part_q;
  logic                      is_master_q, is_replica_q, is_write_q;

  // slot memory
  prt_pkg::entry_t mem_q [prt_pkg::DEPTH];
  prt_pkg::entry_t rdata_q;
  logic [AW-1:0]   raddr, waddr;
  logic            mem_we;
  prt_pkg::entry_t wdata, upd_ent;

  logic            accept, out_free, fin, load;
  prt_pkg::res_t   fin_res, load_res;
  logic            issue, scan_done, ns_hit;
  logic            mt, rt;

  assign accept   = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[waddr] <= wdata;
    end
    rdata_q <= mem_q[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      node_q       <= node_id_i;
      ns_q         <= namespace_index_i;
      part_q       <= partition_i;
      is_master_q  <= is_master_i;
      is_replica_q <= is_replica_i;
      is_write_q   <= is_write_i;
    end
    res_q <= res_d;
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= prt_pkg::ST_CLR;
      cnt_q       <= '0;
      rv_q        <= 1'b0;
      rtag_q      <= '0;
      ns_use_q    <= '0;
      thr_q       <= '0;
      tog_q       <= 1'b0;
      rmo_q       <= 1'b0;
      clr_res_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      rv_q        <= rv_d;
      rtag_q      <= rtag_d;
      ns_use_q    <= ns_use_d;
      thr_q       <= thr_d;
      tog_q       <= tog_d;
      clr_res_q   <= clr_res_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        rmo_q <= cfg_wdata_i;
      end
    end
  end

  // update: drop the node from both slots, then place it
  always_comb begin
    upd_ent      = rdata_q;
    upd_ent.m_ok = rdata_q.m_ok && (rdata_q.m_node != node_q);
    upd_ent.r_ok = rdata_q.r_ok && (rdata_q.r_node != node_q);
    if (is_master_q) begin
      upd_ent.m_ok   = 1'b1;
      upd_ent.m_node = node_q;
    end else if (is_replica_q) begin
      upd_ent.r_ok   = 1'b1;
      upd_ent.r_node = node_q;
    end
  end

  assign mt        = thr_q[rdata_q.m_node];
  assign rt        = thr_q[rdata_q.r_node];
  assign issue     = !cnt_q[AW];
  assign scan_done = cnt_q[AW] && !rv_q;
  assign ns_hit    = ns_use_q[rtag_q[AW-1 -: prt_pkg::NS_W]];

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    rv_d      = 1'b0;
    rtag_d    = rtag_q;
    ns_use_d  = ns_use_q;
    thr_d     = thr_q;
    tog_d     = tog_q;
    clr_res_d = clr_res_q;
    res_d     = res_q;
    raddr     = cnt_q[AW-1:0];
    waddr     = rtag_q;
    wdata     = rdata_q;
    mem_we    = 1'b0;
    fin       = 1'b0;
    fin_res   = '0;
    load      = 1'b0;
    load_res  = res_q;
    in_ready_o = (state_q == prt_pkg::ST_IDLE);

    case (state_q)
      prt_pkg::ST_CLR: begin
        mem_we = 1'b1;
        waddr  = cnt_q[AW-1:0];
        wdata  = '0;
        cnt_d  = cnt_q + 1'b1;
        if (&cnt_q[AW-1:0]) begin
          cnt_d = '0;
          if (clr_res_q) begin
            fin = 1'b1;
          end else begin
            state_d = prt_pkg::ST_IDLE;
          end
        end
      end
      prt_pkg::ST_IDLE: begin
        raddr = {namespace_index_i, partition_i};
        if (in_valid_i) begin
          case (op_i)
            prt_pkg::OP_UPDATE: begin
              ns_use_d[namespace_index_i] = 1'b1;
              state_d = prt_pkg::ST_UPD;
            end
            prt_pkg::OP_LOOKUP: begin
              state_d = prt_pkg::ST_LKP;
            end
            prt_pkg::OP_PRESENCE: begin
              cnt_d   = '0;
              state_d = prt_pkg::ST_SCAN_M;
            end
            prt_pkg::OP_THROTTLE: begin
              thr_d[node_id_i] = throttled_i;
              res_d   = '0;
              state_d = prt_pkg::ST_RESP;
            end
            prt_pkg::OP_CLEAR: begin
              ns_use_d  = '0;
              cnt_d     = '0;
              clr_res_d = 1'b1;
              state_d   = prt_pkg::ST_CLR;
            end
            default: begin
              res_d   = '0;
              state_d = prt_pkg::ST_RESP;
            end
          endcase
        end
      end
      prt_pkg::ST_UPD: begin
        mem_we = 1'b1;
        waddr  = {ns_q, part_q};
        wdata  = upd_ent;
        fin    = 1'b1;
      end
      prt_pkg::ST_LKP: begin
        fin = 1'b1;
        if (ns_use_q[ns_q]) begin
          if (is_write_q || rmo_q || !rdata_q.r_ok) begin
            fin_res.node_valid  = rdata_q.m_ok;
            fin_res.chosen_node = rdata_q.m_ok ? rdata_q.m_node : '0;
          end else if (!rdata_q.m_ok) begin
            fin_res.node_valid  = 1'b1;
            fin_res.chosen_node = rdata_q.r_node;
          end else begin
            fin_res.node_valid = 1'b1;
            if (mt != rt) begin
              fin_res.chosen_node = mt ? rdata_q.r_node : rdata_q.m_node;
            end else begin
              // new toggle value 1 picks master
              tog_d = !tog_q;
              fin_res.chosen_node = tog_q ? rdata_q.r_node : rdata_q.m_node;
            end
          end
        end
      end
      prt_pkg::ST_SCAN_M: begin
        if (issue) begin
          cnt_d  = cnt_q + 1'b1;
          rv_d   = 1'b1;
          rtag_d = cnt_q[AW-1:0];
        end
        if (rv_q && ns_hit && rdata_q.m_ok && (rdata_q.m_node == node_q)) begin
          fin = 1'b1;
          fin_res.node_present = 1'b1;
          rv_d = 1'b0;
        end else if (scan_done) begin
          cnt_d   = '0;
          state_d = prt_pkg::ST_SCAN_R;
        end
      end
      prt_pkg::ST_SCAN_R: begin
        if (issue) begin
          cnt_d  = cnt_q + 1'b1;
          rv_d   = 1'b1;
          rtag_d = cnt_q[AW-1:0];
        end
        if (rv_q && ns_hit && rdata_q.r_ok && (rdata_q.r_node == node_q)) begin
          mem_we     = 1'b1;
          wdata.r_ok = 1'b0;
        end
        if (scan_done) begin
          fin = 1'b1;
        end
      end
      prt_pkg::ST_RESP: begin
        if (out_free) begin
          load    = 1'b1;
          state_d = prt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = prt_pkg::ST_IDLE;
      end
    endcase

    // finished result goes straight out when the output register is free
    if (fin) begin
      clr_res_d = 1'b0;
      if (out_free) begin
        load     = 1'b1;
        load_res = fin_res;
        state_d  = prt_pkg::ST_IDLE;
      end else begin
        res_d   = fin_res;
        state_d = prt_pkg::ST_RESP;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    if (load) begin
      out_valid_d = 1'b1;
      out_d       = load_res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign chosen_node_o  = out_q.chosen_node;
  assign node_valid_o   = out_q.node_valid;
  assign node_present_o = out_q.node_present;

endmodule
`default_nettype wire

FILE: tb/partition_replica_route_table_test.sv
// Testbench for partition_replica_route_table: bursty driver, stalling monitor, scoreboard.
`timescale 1ns / 1ps
module partition_replica_route_table_test;

  localparam int unsigned OP_W       = prt_pkg::OP_W;
  localparam int unsigned NODE_W     = prt_pkg::NODE_W;
  localparam int unsigned NS_W       = prt_pkg::NS_W;
  localparam int unsigned PART_W     = prt_pkg::PART_W;
  localparam int unsigned NAMESPACES = prt_pkg::NAMESPACES;
  localparam int unsigned NODES      = prt_pkg::NODES;
  localparam int unsigned DEPTH      = prt_pkg::DEPTH;

  localparam int unsigned QUIET_LIMIT = 200000;
  localparam int unsigned PHASE_BEATS = 270;
  localparam int unsigned HOT_PARTS   = 6;
  localparam int unsigned HOT_NODES   = 5;

  typedef prt_pkg::entry_t entry_t;
  typedef prt_pkg::res_t   res_t;
  typedef logic [OP_W-1:0]   op_t;
  typedef logic [NODE_W-1:0] node_t;
  typedef logic [PART_W-1:0] part_t;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [NODE_W-1:0] node;
    logic [NS_W-1:0]   ns;
    logic [PART_W-1:0] part;
    logic              mst;
    logic              rep;
    logic              wr;
    logic              thr;
  } route_req_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic              cfg_wdata_i = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [OP_W-1:0]   op_i = '0;
  logic [NODE_W-1:0] node_id_i = '0;
  logic [NS_W-1:0]   namespace_index_i = '0;
  logic [PART_W-1:0] partition_i = '0;
  logic              is_master_i = 1'b0;
  logic              is_replica_i = 1'b0;
  logic              is_write_i = 1'b0;
  logic              throttled_i = 1'b0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [NODE_W-1:0] chosen_node_o;
  logic              node_valid_o;
  logic              node_present_o;

  // shadow of the route table
  entry_t            route_rows [DEPTH];
  logic [NAMESPACES-1:0] ns_live;
  logic [NODES-1:0]  node_throttle;
  logic              tie_bit;
  logic              reads_to_master;

  route_req_t        pending_beats [$];
  res_t              route_answers [$];
  route_req_t        cur_beat;
  int unsigned       burst_left = 1;
  int unsigned       gap_left = 0;
  logic [7:0]        ready_mask = 8'hFF;
  logic [2:0]        ready_pos = '0;
  int unsigned       quiet_cycles = 0;
  int unsigned       mismatches = 0;
  int unsigned       results_seen = 0;
  int unsigned       op_seen [8];
  logic [PART_W-1:0] hot_parts [HOT_PARTS];
  logic [NODE_W-1:0] hot_nodes [HOT_NODES];

  partition_replica_route_table DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .op_i              (op_i),
    .node_id_i         (node_id_i),
    .namespace_index_i (namespace_index_i),
    .partition_i       (partition_i),
    .is_master_i       (is_master_i),
    .is_replica_i      (is_replica_i),
    .is_write_i        (is_write_i),
    .throttled_i       (throttled_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .chosen_node_o     (chosen_node_o),
    .node_valid_o      (node_valid_o),
    .node_present_o    (node_present_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic void wipe_routes();
    for (int i = 0; i < DEPTH; i++) route_rows[i] = '0;
    ns_live = '0;
  endfunction

  function automatic void predict_route(route_req_t q);
    int unsigned row;
    res_t        ans;
    logic        found;
    logic        mt;
    logic        rt;
    row   = 32'({q.ns, q.part});
    ans   = '0;
    found = 1'b0;
    case (q.op)
      prt_pkg::OP_UPDATE: begin
        ns_live[q.ns] = 1'b1;
        if (route_rows[row].m_ok && route_rows[row].m_node == q.node)
          route_rows[row].m_ok = 1'b0;
        if (route_rows[row].r_ok && route_rows[row].r_node == q.node)
          route_rows[row].r_ok = 1'b0;
        if (q.mst) begin
          route_rows[row].m_node = q.node;
          route_rows[row].m_ok   = 1'b1;
        end else if (q.rep) begin
          route_rows[row].r_node = q.node;
          route_rows[row].r_ok   = 1'b1;
        end
      end
      prt_pkg::OP_LOOKUP: begin
        if (ns_live[q.ns]) begin
          if (q.wr || reads_to_master || !route_rows[row].r_ok) begin
            ans.node_valid  = route_rows[row].m_ok;
            ans.chosen_node = route_rows[row].m_ok ? route_rows[row].m_node : '0;
          end else if (!route_rows[row].m_ok) begin
            ans.node_valid  = 1'b1;
            ans.chosen_node = route_rows[row].r_node;
          end else begin
            mt = node_throttle[route_rows[row].m_node];
            rt = node_throttle[route_rows[row].r_node];
            ans.node_valid = 1'b1;
            if (!mt && rt) begin
              ans.chosen_node = route_rows[row].m_node;
            end else if (mt && !rt) begin
              ans.chosen_node = route_rows[row].r_node;
            end else begin
              // equal throttle: alternate, odd toggle goes to master
              tie_bit = ~tie_bit;
              ans.chosen_node = tie_bit ? route_rows[row].m_node : route_rows[row].r_node;
            end
          end
        end
      end
      prt_pkg::OP_PRESENCE: begin
        for (int i = 0; i < DEPTH && !found; i++)
          if (ns_live[i >> PART_W] && route_rows[i].m_ok && route_rows[i].m_node == q.node)
            found = 1'b1;
        ans.node_present = found;
        if (!found)
          for (int i = 0; i < DEPTH; i++)
            if (ns_live[i >> PART_W] && route_rows[i].r_ok && route_rows[i].r_node == q.node)
              route_rows[i].r_ok = 1'b0;
      end
      prt_pkg::OP_THROTTLE: node_throttle[q.node] = q.thr;
      prt_pkg::OP_CLEAR:    wipe_routes();
      default: ;
    endcase
    route_answers.push_back(ans);
  endfunction

  function automatic void check_field(string what, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want, got);
      mismatches++;
    end
  endfunction

  task automatic queue_beat(logic [OP_W-1:0] op, logic [NODE_W-1:0] node,
                            logic [NS_W-1:0] ns, logic [PART_W-1:0] part,
                            logic mst, logic rep, logic wr, logic thr);
    pending_beats.push_back('{op, node, ns, part, mst, rep, wr, thr});
  endtask

  task automatic write_master_only(logic value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    reads_to_master = value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_beats.size() != 0 || in_valid_i || route_answers.size() != 0)
      @(posedge clk_i);
  endtask

  // Mostly well-formed traffic on a small hot set of rows and nodes so that
  // lookups land on live slots, ties and throttles; a few beats are pure noise.
  task automatic queue_random_phase(int unsigned count);
    route_req_t  b;
    int unsigned roll;
    for (int k = 0; k < HOT_PARTS; k++) hot_parts[k] = part_t'($urandom());
    hot_parts[0] = $urandom_range(0, 1) ? '1 : '0;
    for (int k = 0; k < HOT_NODES; k++) hot_nodes[k] = node_t'($urandom());
    repeat (count) begin
      b = route_req_t'({$urandom(), $urandom()});
      roll = $urandom_range(0, 999);
      if (roll >= 15) begin
        b.part = hot_parts[$urandom_range(0, HOT_PARTS - 1)];
        b.node = hot_nodes[$urandom_range(0, HOT_NODES - 1)];
        if (roll < 375)      b.op = prt_pkg::OP_UPDATE;
        else if (roll < 775) b.op = prt_pkg::OP_LOOKUP;
        else if (roll < 900) b.op = prt_pkg::OP_THROTTLE;
        else if (roll < 935)
          b.op = op_t'($urandom_range(int'(prt_pkg::OP_CLEAR) + 1, (1 << OP_W) - 1));
        else if (roll < 942) b.op = prt_pkg::OP_PRESENCE;
        else if (roll < 945) b.op = prt_pkg::OP_CLEAR;
        else begin
          b.op   = prt_pkg::OP_LOOKUP;
          b.part = part_t'($urandom());
        end
      end
      pending_beats.push_back(b);
    end
  endtask

  // driver: bursts of beats with random gaps
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        predict_route(cur_beat);
        op_seen[cur_beat.op]++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pending_beats.size() > 0) begin
          cur_beat = pending_beats.pop_front();
          op_i              <= cur_beat.op;
          node_id_i         <= cur_beat.node;
          namespace_index_i <= cur_beat.ns;
          partition_i       <= cur_beat.part;
          is_master_i       <= cur_beat.mst;
          is_replica_i      <= cur_beat.rep;
          is_write_i        <= cur_beat.wr;
          throttled_i       <= cur_beat.thr;
          in_valid_i        <= 1'b1;
          burst_left--;
          if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 9) == 0) ? 48 : $urandom_range(1, 12);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if ($urandom_range(0, 15) == 0) gap_left = 20;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each result beat and stalls on a rotating mask
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (route_answers.size() == 0) begin
          $display("%0t ns: unexpected result, expected none, got node %0d valid %0b present %0b",
                   $time, chosen_node_o, node_valid_o, node_present_o);
          mismatches++;
        end else begin
          want = route_answers.pop_front();
          check_field("chosen_node", 32'(want.chosen_node), 32'(chosen_node_o));
          check_field("node_valid", 32'(want.node_valid), 32'(node_valid_o));
          check_field("node_present", 32'(want.node_present), 32'(node_present_o));
        end
      end
      out_ready_i <= ready_mask[ready_pos];
      ready_pos++;
      if (ready_pos == 0)
        ready_mask = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom());
    end
  end

  // a presence check may legitimately run two full table sweeps
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t ns: no handshake for %0d cycles", $time, quiet_cycles);
      $display("partition_replica_route_table test failed");
      $finish;
    end
  end

  initial begin
    wipe_routes();
    node_throttle   = '0;
    tie_bit         = 1'b0;
    reads_to_master = 1'b0;
    foreach (op_seen[k]) op_seen[k] = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    write_master_only(1'b0);

    // empty table, extremes, tie alternation, throttle preference
    queue_beat(prt_pkg::OP_LOOKUP,   '0,    '0,    '0,    1'b0, 1'b0, 1'b0, 1'b0);
    queue_beat(prt_pkg::OP_UPDATE,   '1,    '1,    '1,    1'b1, 1'b0, 1'b0, 1'b0);
    queue_beat(prt_pkg::OP_UPDATE,   '0,    '1,    '1,    1'b0, 1'b1, 1'b0, 1'b0);
    queue_beat(prt_pkg::OP_LOOKUP,   '0,    '1,    '1,    1'b0, 1'b0, 1'b0, 1'b0);
    queue_beat(prt_pkg::OP_LOOKUP,   '0,    '1,    '1,    1'b0, 1'b0, 1'b0, 1'b0);
    queue_beat(prt_pkg::OP_LOOKUP,   '0,    '1,    '1,    1'b0, 1'b0, 1'b1, 1'b0);
    queue_beat(prt_pkg::OP_THROTTLE, '1,    '0,    '0,    1'b0, 1'b0, 1'b0, 1'b1);
    queue_beat(prt_pkg::OP_LOOKUP,   '0,    '1,    '1,    1'b0, 1'b0, 1'b0, 1'b0);
    queue_beat(prt_pkg::OP_THROTTLE, '0,    '0,    '0,    1'b0, 1'b0, 1'b0, 1'b1);
    queue_beat(prt_pkg::OP_LOOKUP,   '0,    '1,    '1,    1'b0, 1'b0, 1'b0, 1'b0);
    // drop master: read falls to replica, write finds nothing
    queue_beat(prt_pkg::OP_UPDATE,   '1,    '1,    '1,    1'b0, 1'b0, 1'b0, 1'b0);
    queue_beat(prt_pkg::OP_LOOKUP,   '0,    '1,    '1,    1'b0, 1'b0, 1'b0, 1'b0);
    queue_beat(prt_pkg::OP_LOOKUP,   '0,    '1,    '1,    1'b0, 1'b0, 1'b1, 1'b0);
    // node that is master nowhere loses its replica slots
    queue_beat(prt_pkg::OP_PRESENCE, '0,    '0,    '0,    1'b0, 1'b0, 1'b0, 1'b0);
    queue_beat(prt_pkg::OP_LOOKUP,   '0,    '1,    '1,    1'b0, 1'b0, 1'b0, 1'b0);
    queue_beat(prt_pkg::OP_UPDATE,   6'd5,  '0,    '0,    1'b1, 1'b1, 1'b0, 1'b0);
    queue_beat(prt_pkg::OP_UPDATE,   6'd5,  '0,    '0,    1'b0, 1'b1, 1'b0, 1'b0);
    queue_beat(prt_pkg::OP_UPDATE,   6'd9,  '0,    '0,    1'b1, 1'b0, 1'b0, 1'b0);
    queue_beat(prt_pkg::OP_PRESENCE, 6'd9,  '0,    '0,    1'b0, 1'b0, 1'b0, 1'b0);
    queue_beat(prt_pkg::OP_PRESENCE, 6'd5,  '0,    '0,    1'b0, 1'b0, 1'b0, 1'b0);
    queue_beat('1,                   '1,    '1,    '1,    1'b1, 1'b1, 1'b1, 1'b1);
    queue_beat(3'(int'(prt_pkg::OP_CLEAR) + 1), 6'd9, '0, '0, 1'b0, 1'b0, 1'b0, 1'b0);
    queue_beat(prt_pkg::OP_THROTTLE, '0,    '0,    '0,    1'b0, 1'b0, 1'b0, 1'b0);
    queue_beat(prt_pkg::OP_CLEAR,    '0,    '0,    '0,    1'b0, 1'b0, 1'b0, 1'b0);
    queue_beat(prt_pkg::OP_LOOKUP,   '0,    '0,    '0,    1'b0, 1'b0, 1'b0, 1'b0);
    wait_drained();

    // master-only reads, with and without a live master
    write_master_only(1'b1);
    queue_beat(prt_pkg::OP_UPDATE,   6'd12, 2'd1,  12'd7, 1'b1, 1'b0, 1'b0, 1'b0);
    queue_beat(prt_pkg::OP_UPDATE,   6'd34, 2'd1,  12'd7, 1'b0, 1'b1, 1'b0, 1'b0);
    queue_beat(prt_pkg::OP_LOOKUP,   '0,    2'd1,  12'd7, 1'b0, 1'b0, 1'b0, 1'b0);
    queue_beat(prt_pkg::OP_UPDATE,   6'd12, 2'd1,  12'd7, 1'b0, 1'b0, 1'b0, 1'b0);
    queue_beat(prt_pkg::OP_LOOKUP,   '0,    2'd1,  12'd7, 1'b0, 1'b0, 1'b0, 1'b0);
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      write_master_only(ph % 2 == 1);
      queue_random_phase(PHASE_BEATS);
      wait_drained();
    end
    repeat (40) @(posedge clk_i);

    $display("beats: %0d updates, %0d lookups, %0d presence checks, %0d throttle writes,",
             op_seen[prt_pkg::OP_UPDATE], op_seen[prt_pkg::OP_LOOKUP],
             op_seen[prt_pkg::OP_PRESENCE], op_seen[prt_pkg::OP_THROTTLE]);
    $display("%0d clears, %0d spare ops; %0d results checked over balanced and master-only reads",
             op_seen[prt_pkg::OP_CLEAR], op_seen[5] + op_seen[6] + op_seen[7], results_seen);
    if (mismatches == 0) begin
      $display("partition_replica_route_table test passed");
    end else begin
      $display("partition_replica_route_table test failed");
    end
    $finish;
  end

endmodule
